/* rtl/qfit_pkg.sv */
// ----------------------------------------------------------------------------
// qfit_pkg: shared types and constants of the three-point quadratic fit
// Field widths, divider geometry and the item that travels down the divider.
// ----------------------------------------------------------------------------
package qfit_pkg;

	localparam int VW = 14;          // voltage, Q2.12
	localparam int YW = 20;          // reference value, Q12.8
	localparam int TW = 40;          // determinant threshold
	localparam int CW = 48;          // coefficient, Q31.16
	localparam int DW = 42;          // determinant magnitude
	localparam int QW = 50;          // quotient bits, one extra for rounding
	localparam int XW = QW + 22;     // doubled scaled dividend
	localparam int NSTEP = QW;       // divider cells

	localparam logic [TW-1:0] THR_RESET = 40'd68719;
	localparam logic [CW-1:0] CAP_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [CW-1:0] CAP_NEG = 48'h8000_0000_0000;

	// one lane of a restoring division: partial remainder and the shift word
	// (dividend bits still to come on the left, quotient bits on the right)
	typedef struct packed {
		logic [DW-1:0] r;
		logic [QW-1:0] w;
	} lane_t;

	typedef struct packed {
		logic       fit;
		logic [2:0] ovf;
		logic [2:0] neg;
	} flags_t;

	typedef struct packed {
		logic [DW-1:0] d;
		lane_t [2:0]   lane;
		flags_t        flags;
	} div_item_t;

endpackage

/* rtl/qfit_if.sv */
// ----------------------------------------------------------------------------
// qfit_if: item channels of the quadratic fit
// Calibration point channel and coefficient channel, valid/ready.
// ----------------------------------------------------------------------------
interface qfit_pts_if;
	logic        valid;
	logic        ready;
	logic [13:0] volt_first;
	logic [13:0] volt_second;
	logic [13:0] volt_third;
	logic [19:0] ref_first;
	logic [19:0] ref_second;
	logic [19:0] ref_third;

	modport source (output valid, volt_first, volt_second, volt_third,
		ref_first, ref_second, ref_third, input ready);
	modport sink (input valid, volt_first, volt_second, volt_third,
		ref_first, ref_second, ref_third, output ready);
endinterface

interface qfit_coef_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] coef_square;
	logic signed [47:0] coef_linear;
	logic signed [47:0] coef_const;
	logic               fit_valid;
	logic               saturated;

	modport source (output valid, coef_square, coef_linear, coef_const,
		fit_valid, saturated, input ready);
	modport sink (input valid, coef_square, coef_linear, coef_const,
		fit_valid, saturated, output ready);
endinterface

/* rtl/qfit_front.sv */
// ----------------------------------------------------------------------------
// qfit_front: determinant and numerators
// Six stages form D, Na, Nb, Nc exactly and set up the three divider lanes.
// ----------------------------------------------------------------------------
module qfit_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [qfit_pkg::TW-1:0] thr,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic [qfit_pkg::VW-1:0] v_in [3],
	input  logic [qfit_pkg::YW-1:0] y_in [3],
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output qfit_pkg::div_item_t     dn_data
);
	import qfit_pkg::*;

	localparam int NS = 6;

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	logic [VW-1:0]        v_s1 [3];
	logic [YW-1:0]        y_s1 [3];
	logic signed [VW:0]   u_s2 [3];
	logic [VW:0]          sm_s2 [3];
	logic [2*VW-1:0]      m_s2 [3];
	logic [YW-1:0]        y_s2 [3];
	logic signed [35:0]   a_s3 [3];
	logic signed [29:0]   b_s3 [3];
	logic signed [43:0]   c_s3 [3];
	logic signed [29:0]   e_s3;
	logic signed [VW:0]   u3_s3;
	logic [YW-1:0]        y_s3 [3];
	logic signed [37:0]   na_s4;
	logic signed [50:0]   pb_s4 [3];
	logic signed [64:0]   pc_s4 [3];
	logic signed [44:0]   det_s4;
	logic signed [37:0]   na_s5;
	logic signed [52:0]   nb_s5;
	logic signed [66:0]   nc_s5;
	logic signed [44:0]   det_s5;
	div_item_t            item_s6;

	assign rdy[NS] = dn_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = ~vld_q[k] | rdy[k+1];
	end
	assign up_ready = rdy[0];
	assign dn_valid = vld_q[NS-1];
	assign dn_data  = item_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= up_valid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			v_s1 <= v_in;
			y_s1 <= y_in;
		end
	end

	// stage 2: differences, sums and pair products of the other two voltages
	for (genvar i = 0; i < 3; i++) begin : g_s2
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (rdy[1]) begin
				u_s2[i]  <= signed'({1'b0, v_s1[J]}) - signed'({1'b0, v_s1[K]});
				sm_s2[i] <= {1'b0, v_s1[J]} + {1'b0, v_s1[K]};
				m_s2[i]  <= v_s1[J] * v_s1[K];
				y_s2[i]  <= y_s1[i];
			end
		end
	end

	// stage 3
	for (genvar i = 0; i < 3; i++) begin : g_s3
		always_ff @(posedge clk) begin
			if (rdy[2]) begin
				a_s3[i] <= signed'({1'b0, y_s2[i]}) * u_s2[i];
				b_s3[i] <= u_s2[i] * signed'({1'b0, sm_s2[i]});
				c_s3[i] <= u_s2[i] * signed'({1'b0, m_s2[i]});
				y_s3[i] <= y_s2[i];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			e_s3  <= u_s2[0] * u_s2[1];
			u3_s3 <= u_s2[2];
		end
	end

	// stage 4
	for (genvar i = 0; i < 3; i++) begin : g_s4
		always_ff @(posedge clk) begin
			if (rdy[3]) begin
				pb_s4[i] <= signed'({1'b0, y_s3[i]}) * b_s3[i];
				pc_s4[i] <= signed'({1'b0, y_s3[i]}) * c_s3[i];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			na_s4  <= 38'(a_s3[0]) + 38'(a_s3[1]) + 38'(a_s3[2]);
			det_s4 <= -(e_s3 * u3_s3);
		end
	end

	// stage 5
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			na_s5  <= na_s4;
			nb_s5  <= -(53'(pb_s4[0]) + 53'(pb_s4[1]) + 53'(pb_s4[2]));
			nc_s5  <= 67'(pc_s4[0]) + 67'(pc_s4[1]) + 67'(pc_s4[2]);
			det_s5 <= det_s4;
		end
	end

	// stage 6: magnitudes, signs, threshold and overflow checks
	logic [44:0]   det_mag;
	logic [DW-1:0] dmag;
	logic [37:0]   na_mag;
	logic [52:0]   nb_mag;
	logic [66:0]   nc_mag;
	logic [XW-1:0] x2 [3];
	div_item_t     item_d;

	always_comb begin
		det_mag = det_s5[44] ? 45'(-det_s5) : 45'(det_s5);
		dmag    = det_mag[DW-1:0];
		na_mag  = na_s5[37] ? 38'(-na_s5) : 38'(na_s5);
		nb_mag  = nb_s5[52] ? 53'(-nb_s5) : 53'(nb_s5);
		nc_mag  = nc_s5[66] ? 67'(-nc_s5) : 67'(nc_s5);
		// doubled dividends: 2*|N|*2^sh, sh = 32, 20, 8
		x2[2] = XW'(na_mag) << 33;
		x2[1] = XW'(nb_mag) << 21;
		x2[0] = XW'(nc_mag) << 9;
		item_d.d         = dmag;
		item_d.flags.fit = (det_s5 != '0) && (det_mag >= 45'(thr));
		item_d.flags.neg = {na_s5[37] ^ det_s5[44], nb_s5[52] ^ det_s5[44],
			nc_s5[66] ^ det_s5[44]};
		for (int i = 0; i < 3; i++) begin
			item_d.lane[i].r = DW'(x2[i][XW-1:QW]);
			item_d.lane[i].w = x2[i][QW-1:0];
			item_d.flags.ovf[i] = DW'(x2[i][XW-1:QW]) >= dmag;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) item_s6 <= item_d;
	end

endmodule

/* rtl/qfit_div_cell.sv */
// ----------------------------------------------------------------------------
// qfit_div_cell: one restoring-division step on three lanes
// Shift in the next dividend bit, subtract the divisor where it fits.
// ----------------------------------------------------------------------------
module qfit_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  qfit_pkg::div_item_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output qfit_pkg::div_item_t dn_data
);
	import qfit_pkg::*;

	logic      vld_q;
	div_item_t item_q;
	div_item_t item_d;
	logic [DW:0] t [3];
	logic        ge [3];

	assign up_ready = ~vld_q | dn_ready;
	assign dn_valid = vld_q;
	assign dn_data  = item_q;

	always_comb begin
		item_d = up_data;
		for (int i = 0; i < 3; i++) begin
			t[i]  = {up_data.lane[i].r, up_data.lane[i].w[QW-1]};
			ge[i] = t[i] >= {1'b0, up_data.d};
			item_d.lane[i].r = ge[i] ? DW'(t[i] - {1'b0, up_data.d}) : t[i][DW-1:0];
			item_d.lane[i].w = {up_data.lane[i].w[QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (up_ready) vld_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready) item_q <= item_d;
	end

endmodule

/* rtl/qfit_round.sv */
// ----------------------------------------------------------------------------
// qfit_round: rounding, clipping and sign of the coefficients
// Output register of the block.
// ----------------------------------------------------------------------------
module qfit_round (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  qfit_pkg::div_item_t          up_data,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output logic signed [qfit_pkg::CW-1:0] coef [3],
	output logic                         fit_valid,
	output logic                         saturated
);
	import qfit_pkg::*;

	logic              vld_q;
	logic [CW-1:0]     coef_q [3];
	logic              fit_q;
	logic              sat_q;
	logic [QW:0]       rnd_full [3];
	logic [QW-1:0]     rnd [3];
	logic [CW-1:0]     cap [3];
	logic [CW-1:0]     mag [3];
	logic [2:0]        clip;
	logic [CW-1:0]     coef_d [3];

	assign up_ready  = ~vld_q | dn_ready;
	assign dn_valid  = vld_q;
	assign fit_valid = fit_q;
	assign saturated = sat_q;
	for (genvar i = 0; i < 3; i++) begin : g_out
		assign coef[i] = signed'(coef_q[i]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// round half away from zero on the magnitude
			rnd_full[i] = {1'b0, up_data.lane[i].w} + (QW+1)'(1);
			rnd[i]      = rnd_full[i][QW:1];
			cap[i]      = up_data.flags.neg[i] ? CAP_NEG : CAP_POS;
			clip[i]     = up_data.flags.ovf[i] || (rnd[i] > QW'(cap[i]));
			mag[i]      = clip[i] ? cap[i] : rnd[i][CW-1:0];
			coef_d[i]   = !up_data.flags.fit ? '0 :
				(up_data.flags.neg[i] ? -mag[i] : mag[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (up_ready) vld_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			coef_q <= coef_d;
			fit_q  <= up_data.flags.fit;
			sat_q  <= up_data.flags.fit && (|clip);
		end
	end

endmodule

/* rtl/quadratic_fit_three_points.sv */
// ----------------------------------------------------------------------------
// quadratic_fit_three_points: y = a*v^2 + b*v + c through three points
// Exact Cramer's rule on the Vandermonde system with a pipelined divider.
// ----------------------------------------------------------------------------
// Usage
//   points carries one item per fit: three Q2.12 voltages and three Q12.8
//   reference values. coefs returns one item per fit: a, b, c in Q31.16,
//   fit_valid and saturated. Items leave in the order they arrived.
//   det_threshold is written through cfg_we / cfg_wdata while the block is
//   idle; a fit whose |D| falls below it, or whose D is zero, comes out with
//   fit_valid low and all coefficients and saturated at zero.
// Timing
//   One item per cycle sustained while coefs.ready is high. There are 57
//   registers in line: six stages form D and the numerators, a chain of 50
//   division cells yields one quotient bit each for all three lanes, and a
//   final stage rounds, clips and drives the output register. The first
//   stage loads at the accepting edge.
// Reset and stall
//   arst_n empties every stage and loads det_threshold with 68719.
//   Each stage holds its item while the next one is full and stalled, so a
//   stalled receiver fills the chain bubble by bubble before points.ready
//   drops; an empty slot anywhere lets a new item in.
// ----------------------------------------------------------------------------
module quadratic_fit_three_points (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [qfit_pkg::TW-1:0] cfg_wdata,
	qfit_pts_if.sink                points,
	qfit_coef_if.source             coefs
);
	import qfit_pkg::*;

	logic [TW-1:0] det_threshold_q;

	logic [VW-1:0] v_in [3];
	logic [YW-1:0] y_in [3];

	// handshake chain from the front end through every divider cell
	div_item_t     chain_d [NSTEP+1];
	logic [NSTEP:0] chain_v;
	logic [NSTEP:0] chain_r;

	logic signed [CW-1:0] coef [3];

	// threshold register: to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) det_threshold_q <= THR_RESET;
		else if (cfg_we) det_threshold_q <= cfg_wdata;
	end

	assign v_in[0] = points.volt_first;
	assign v_in[1] = points.volt_second;
	assign v_in[2] = points.volt_third;
	assign y_in[0] = points.ref_first;
	assign y_in[1] = points.ref_second;
	assign y_in[2] = points.ref_third;

	// form D, Na, Nb, Nc and load the divider lanes
	qfit_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (det_threshold_q),
		.up_valid (points.valid),
		.up_ready (points.ready),
		.v_in     (v_in),
		.y_in     (y_in),
		.dn_valid (chain_v[0]),
		.dn_ready (chain_r[0]),
		.dn_data  (chain_d[0])
	);

	// one quotient bit per cell, lane order: 2 = a, 1 = b, 0 = c
	for (genvar k = 0; k < NSTEP; k++) begin : g_cell
		qfit_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_v[k]),
			.up_ready (chain_r[k]),
			.up_data  (chain_d[k]),
			.dn_valid (chain_v[k+1]),
			.dn_ready (chain_r[k+1]),
			.dn_data  (chain_d[k+1])
		);
	end

	// round, clip, apply sign; this is the output register
	qfit_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (chain_v[NSTEP]),
		.up_ready  (chain_r[NSTEP]),
		.up_data   (chain_d[NSTEP]),
		.dn_valid  (coefs.valid),
		.dn_ready  (coefs.ready),
		.coef      (coef),
		.fit_valid (coefs.fit_valid),
		.saturated (coefs.saturated)
	);

	assign coefs.coef_square = coef[2];
	assign coefs.coef_linear = coef[1];
	assign coefs.coef_const  = coef[0];

endmodule

/* rtl/qfit_checker.sv */
// ----------------------------------------------------------------------------
// qfit_checker: port-level checks of the quadratic fit
// Output behaviour seen at the coefficient channel, bound to the top level.
// ----------------------------------------------------------------------------
module qfit_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] coef_square,
	input logic [47:0] coef_linear,
	input logic [47:0] coef_const,
	input logic        fit_valid,
	input logic        saturated
);
	import qfit_pkg::*;

	// nothing leaves while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("coefficient item shown during reset");

	// a rejected fit carries zeros only
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fit_valid |->
			coef_square == '0 && coef_linear == '0 && coef_const == '0 && !saturated)
		else $error("rejected fit with non-zero payload");

	// a clipped fit has at least one coefficient sitting on a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			coef_square == CAP_POS || coef_square == CAP_NEG ||
			coef_linear == CAP_POS || coef_linear == CAP_NEG ||
			coef_const == CAP_POS || coef_const == CAP_NEG)
		else $error("saturated set with no coefficient at a bound");

	// hold a stalled item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coef_square) &&
			$stable(coef_linear) && $stable(coef_const) && $stable(fit_valid) &&
			$stable(saturated))
		else $error("stalled coefficient item changed");

endmodule

bind quadratic_fit_three_points qfit_checker u_qfit_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (coefs.valid),
	.out_ready   (coefs.ready),
	.coef_square (coefs.coef_square),
	.coef_linear (coefs.coef_linear),
	.coef_const  (coefs.coef_const),
	.fit_valid   (coefs.fit_valid),
	.saturated   (coefs.saturated)
);
